// ===== hw/rtl/pswh_pkg.sv =====
package pswh_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned HashW = 64;

  // Byte values used by the path fold.
  localparam logic [7:0] BackslashChar = 8'h5C;
  localparam logic [7:0] SlashChar     = 8'h2F;
  localparam logic [7:0] CaseFoldMask  = 8'hDF;

  // Mixing constants.
  localparam logic [43:0] MixMul  = 44'hFB8C4D96501;
  localparam logic [26:0] HashMul = 27'h633D5F1;
  localparam logic [55:0] LenMul  = 56'hAE502812AA7333;

  localparam int unsigned MixShift  = 24;
  localparam int unsigned FoldShift = 61;

  // Constant halves for the split multiplies.
  localparam logic [21:0] MixLo = MixMul[21:0];
  localparam logic [21:0] MixHi = MixMul[43:22];
  localparam logic [27:0] LenLo = LenMul[27:0];
  localparam logic [27:0] LenHi = LenMul[55:28];

  typedef logic [WordW-1:0] word_t;
  typedef logic [HashW-1:0] hash_t;

endpackage

// ===== hw/rtl/pswh_if.sv =====
interface pswh_in_if;
  logic                valid;
  logic                ready;
  pswh_pkg::word_t     text_word;

  modport source (output valid, output text_word, input ready);
  modport sink   (input valid, input text_word, output ready);
endinterface

interface pswh_out_if;
  logic                valid;
  logic                ready;
  pswh_pkg::hash_t     guid;

  modport source (output valid, output guid, input ready);
  modport sink   (input valid, input guid, output ready);
endinterface

// ===== hw/rtl/path_string_word_hash_top.sv =====
// Path string word hash.
// The words channel takes a zero-terminated path string four bytes per
// transfer, first byte in bits 7:0. Bytes after the first zero byte are
// ignored. Each word without a zero byte is folded into a 64-bit running
// hash; the word holding the terminator produces one transfer on the ids
// channel carrying guid, after which the hash and the length count clear.
// Throughput is one word per cycle while stalls on ids have not filled the
// pipeline. The running hash update (one constant multiply of the hash plus
// the mixed word) sits in a single loop stage, and that stage sets the rate.
// The guid of a string is built in stages 4 to 6 after its terminating word
// leaves the loop stage, and appears on ids from the output register.
// The datapath is a six-stage pipeline whose stages close up bubbles: while
// ids is stalled, words keeps accepting until the three stages after the
// loop hold finished results, a terminating word waits in the loop stage
// and the two stages ahead of it are full. Words with no terminator never
// occupy the stages after the loop. A stalled result holds guid stable.
// Synchronous reset empties the pipeline and clears the hash and the
// length count; words.ready is high in the cycle after reset.
module path_string_word_hash_top (
  input  logic              clk,
  input  logic              rst,
  pswh_in_if.sink           words,
  pswh_out_if.source        ids
);

  // Stage 1: input register.
  logic              s1_v;
  pswh_pkg::word_t   s1_word;
  // Stage 2: split mix products.
  logic              s2_v;
  logic              s2_term;
  logic [1:0]        s2_pos;
  logic [53:0]       s2_plo;
  logic [53:0]       s2_phi;
  // Stage 3: mixed word.
  logic              s3_v;
  logic              s3_term;
  logic [1:0]        s3_pos;
  logic [39:0]       s3_mix;
  // Loop state.
  pswh_pkg::hash_t   running_hash;
  logic [31:0]       byte_count;
  // Stage 4: hash sum and length of a finished string.
  logic              s4_v;
  pswh_pkg::hash_t   s4_sum;
  logic [31:0]       s4_len;
  // Stage 5: length products.
  logic              s5_v;
  pswh_pkg::hash_t   s5_sum;
  logic [59:0]       s5_llo;
  logic [35:0]       s5_lhi;
  // Stage 6: output register.
  logic              s6_v;
  pswh_pkg::hash_t   s6_guid;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  // A stage moves on when it is empty or the stage after it moves on.
  // A word without a terminator leaves stage 3 into the loop state only.
  assign rdy6 = !s6_v || ids.ready;
  assign rdy5 = !s5_v || rdy6;
  assign rdy4 = !s4_v || rdy5;
  assign rdy3 = !s3_v || !s3_term || rdy4;
  assign rdy2 = !s2_v || rdy3;
  assign rdy1 = !s1_v || rdy2;

  assign words.ready = rdy1;
  assign ids.valid   = s6_v;
  assign ids.guid    = s6_guid;

  // Byte scan and fold of the registered word.
  logic [31:0] folded;
  logic        term;
  logic [1:0]  pos;

  always_comb begin
    logic       live;
    logic [7:0] b;
    folded = '0;
    term   = 1'b0;
    pos    = '0;
    live   = 1'b1;
    for (int i = 0; i < 4; i++) begin
      b = s1_word[8*i +: 8];
      if (live) begin
        if (b == 8'h00) begin
          term = 1'b1;
          pos  = 2'(i);
          live = 1'b0;
        end else begin
          if (b == pswh_pkg::BackslashChar) begin
            b = pswh_pkg::SlashChar;
          end
          folded[8*i +: 8] = b & pswh_pkg::CaseFoldMask;
        end
      end
    end
  end

  logic [53:0] mix_plo, mix_phi;
  assign mix_plo = 54'(pswh_pkg::MixLo) * 54'(folded);
  assign mix_phi = 54'(pswh_pkg::MixHi) * 54'(folded);

  logic [63:0] mix_prod;
  assign mix_prod = {10'b0, s2_plo} + {s2_phi[41:0], 22'b0};

  // Loop stage: the hash times its constant, cut into two 32-bit halves.
  logic [58:0]     hm_lo;
  logic [31:0]     hm_hi;
  pswh_pkg::hash_t hash_sum;
  pswh_pkg::hash_t hash_fold;
  logic [31:0]     str_len;

  assign hm_lo     = 59'(pswh_pkg::HashMul) * 59'(running_hash[31:0]);
  assign hm_hi     = 32'(pswh_pkg::HashMul) * running_hash[63:32];
  assign hash_sum  = {5'b0, hm_lo} + {hm_hi, 32'b0} + {24'b0, s3_mix};
  assign hash_fold = hash_sum ^ (hash_sum >> pswh_pkg::FoldShift);
  assign str_len   = byte_count + {30'b0, s3_pos};

  logic [59:0] len_lo;
  logic [35:0] len_hi;
  assign len_lo = 60'(pswh_pkg::LenLo) * 60'(s4_len);
  assign len_hi = 36'(pswh_pkg::LenHi) * 36'(s4_len);

  pswh_pkg::hash_t len_prod;
  assign len_prod = {4'b0, s5_llo} + {s5_lhi, 28'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v         <= 1'b0;
      s2_v         <= 1'b0;
      s3_v         <= 1'b0;
      s4_v         <= 1'b0;
      s5_v         <= 1'b0;
      s6_v         <= 1'b0;
      running_hash <= '0;
      byte_count   <= '0;
    end else begin
      if (rdy1) begin
        s1_v <= words.valid;
      end
      if (rdy2) begin
        s2_v <= s1_v;
      end
      if (rdy3) begin
        s3_v <= s2_v;
      end
      if (rdy4) begin
        s4_v <= s3_v && s3_term;
      end
      if (rdy5) begin
        s5_v <= s4_v;
      end
      if (rdy6) begin
        s6_v <= s5_v;
      end
      if (s3_v && rdy3) begin
        if (s3_term) begin
          running_hash <= '0;
          byte_count   <= '0;
        end else begin
          running_hash <= hash_fold;
          byte_count   <= byte_count + 32'd4;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_word <= words.text_word;
    end
    if (rdy2) begin
      s2_term <= term;
      s2_pos  <= pos;
      s2_plo  <= mix_plo;
      s2_phi  <= mix_phi;
    end
    if (rdy3) begin
      s3_term <= s2_term;
      s3_pos  <= s2_pos;
      s3_mix  <= mix_prod[63:pswh_pkg::MixShift];
    end
    if (rdy4) begin
      s4_sum <= hash_sum;
      s4_len <= str_len;
    end
    if (rdy5) begin
      s5_sum <= s4_sum;
      s5_llo <= len_lo;
      s5_lhi <= len_hi;
    end
    if (rdy6) begin
      s6_guid <= s5_sum - len_prod;
    end
  end

endmodule

// ===== hw/rtl/pswh_checker.sv =====
module pswh_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input pswh_pkg::hash_t guid
);

  // Reset empties the output stage.
  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // With no result waiting, nothing can block the words channel.
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready while the output is empty");

  a_stall_keeps_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result dropped");

  a_stall_keeps_guid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(guid))
    else $error("stalled guid changed");

endmodule

bind path_string_word_hash_top pswh_checker u_pswh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (words.ready),
  .out_valid (ids.valid),
  .out_ready (ids.ready),
  .guid      (ids.guid)
);

// ===== tb/tb_path_string_word_hash_top.sv =====
`timescale 1ns / 100ps

// Predicts the guid of each path string from the words seen on the input side
// and checks the ids stream against those predictions in order.
class guid_board;
  localparam logic [63:0] MIX_FACTOR  = 64'h0000_0FB8_C4D9_6501;
  localparam logic [63:0] HASH_FACTOR = 64'h0000_0000_0633_D5F1;
  localparam logic [63:0] LEN_FACTOR  = 64'h00AE_5028_12AA_7333;
  localparam logic [7:0]  BACKSLASH   = 8'h5C;
  localparam logic [7:0]  SLASH       = 8'h2F;
  localparam logic [7:0]  CASE_MASK   = 8'hDF;

  pswh_pkg::hash_t running_hash;
  logic [31:0]     byte_count;
  pswh_pkg::hash_t expected_ids[$];
  int              errors;
  int              matched;
  int              longest;

  function new();
    running_hash = '0;
    byte_count   = '0;
    errors       = 0;
    matched      = 0;
    longest      = 0;
  endfunction

  function int pending();
    return expected_ids.size();
  endfunction

  function void note_word(pswh_pkg::word_t w);
    logic [7:0]      ch;
    logic [31:0]     folded;
    logic [31:0]     len;
    pswh_pkg::hash_t mixed;
    pswh_pkg::hash_t scaled;
    pswh_pkg::hash_t sum;
    bit              ended;
    int              pos;
    folded = '0;
    ended  = 1'b0;
    pos    = 0;
    for (int i = 0; i < 4; i++) begin
      ch = w[8*i +: 8];
      if (!ended) begin
        if (ch == 8'h00) begin
          ended = 1'b1;
          pos   = i;
        end else begin
          if (ch == BACKSLASH) ch = SLASH;
          folded[8*i +: 8] = ch & CASE_MASK;
        end
      end
    end
    // The product wraps at 64 bits before the shift.
    mixed  = MIX_FACTOR * {32'b0, folded};
    mixed  = mixed >> 24;
    scaled = HASH_FACTOR * running_hash;
    if (!ended) begin
      sum          = scaled + mixed;
      running_hash = sum ^ (sum >> 61);
      byte_count   = byte_count + 32'd4;
    end else begin
      len = byte_count + 32'(pos);
      expected_ids.push_back(mixed + scaled - LEN_FACTOR * {32'b0, len});
      if (int'(len) > longest) longest = int'(len);
      running_hash = '0;
      byte_count   = '0;
    end
  endfunction

  function void check_guid(pswh_pkg::hash_t got);
    pswh_pkg::hash_t want;
    if (expected_ids.size() == 0) begin
      $error("guid: transfer with no string pending, actual %h", got);
      errors++;
    end else begin
      want = expected_ids.pop_front();
      if (got !== want) begin
        $error("guid mismatch: expected %h, actual %h", want, got);
        errors++;
      end
      matched++;
    end
  endfunction
endclass

module tb_path_string_word_hash_top;
  localparam int TOTAL_WORDS = 1100;
  localparam int QUIET_FROM  = 950;
  localparam int STALL_LIMIT = 2000;

  logic clk;
  logic rst;
  bit   quiet;
  int   sent;
  int   idle_cycles;

  pswh_in_if  words_ch ();
  pswh_out_if ids_ch ();

  guid_board board;

  pswh_pkg::word_t directed_words [14] = '{
    32'h0000_0000,  // empty string
    32'hFFFF_FF00,  // empty string, junk after the terminator
    32'h0000_005C,  // lone backslash
    32'h0000_6162,
    32'h005C_2F41,
    32'h5C5C_5C5C,
    32'h0101_0101,
    32'h8080_8080,
    32'hFFFF_FFFF,
    32'hDFDF_DFDF,
    32'h7A61_5A41,
    32'h0000_0000,  // terminator on a word boundary
    32'h6F6F_662F,
    32'h1200_5C5C   // terminator in the third byte, junk after it
  };

  path_string_word_hash_top uut (
    .clk   (clk),
    .rst   (rst),
    .words (words_ch),
    .ids   (ids_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [7:0] rand_char();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(8'h61, 8'h7A));
      1: return 8'($urandom_range(8'h41, 8'h5A));
      2: return 8'h5C;
      3: return 8'h2F;
      4: return 8'($urandom_range(8'h80, 8'hFF));
      default: return 8'($urandom_range(1, 255));
    endcase
  endfunction

  function automatic pswh_pkg::word_t body_word();
    pswh_pkg::word_t w;
    for (int i = 0; i < 4; i++) w[8*i +: 8] = rand_char();
    return w;
  endfunction

  function automatic pswh_pkg::word_t tail_word();
    pswh_pkg::word_t w;
    int              pos;
    pos = $urandom_range(0, 3);
    for (int i = 0; i < 4; i++) begin
      if (i < pos) w[8*i +: 8] = rand_char();
      else if (i == pos) w[8*i +: 8] = 8'h00;
      else w[8*i +: 8] = 8'($urandom_range(0, 255));
    end
    return w;
  endfunction

  task automatic send_word(input pswh_pkg::word_t w);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      words_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    words_ch.valid     <= 1'b1;
    words_ch.text_word <= w;
    @(posedge clk);
    while (!words_ch.ready) @(posedge clk);
    board.note_word(w);
    sent++;
  endtask

  // Paths are trimmed so that the run stays close to the planned word count.
  task automatic send_path(input int nwords);
    int n;
    n = nwords;
    if (n > TOTAL_WORDS - sent) n = TOTAL_WORDS - sent;
    if (n < 1) n = 1;
    for (int k = 0; k < n - 1; k++) send_word(body_word());
    send_word(tail_word());
  endtask

  // Holds the input side off until every pending guid has been checked.
  task automatic hold_until_drained();
    words_ch.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  initial begin
    int  pick;
    bit  paused_mid;
    board      = new();
    quiet      = 1'b0;
    sent       = 0;
    paused_mid = 1'b0;
    rst                <= 1'b1;
    words_ch.valid     <= 1'b0;
    words_ch.text_word <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_words[i]) send_word(directed_words[i]);
    hold_until_drained();

    while (sent < TOTAL_WORDS) begin
      if (sent >= QUIET_FROM) quiet = 1'b1;
      if (!paused_mid && sent >= TOTAL_WORDS / 2) begin
        hold_until_drained();
        paused_mid = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) send_word($urandom());
      else if (pick < 10) send_path($urandom_range(60, 200));
      else if (pick < 35) send_path($urandom_range(5, 16));
      else send_path($urandom_range(1, 4));
    end
    words_ch.valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d words and %0d path strings, the longest %0d bytes long.",
             sent, board.matched, board.longest);
    $display("Both channels stalled in random bursts; the input side drained twice.");
    if (board.errors == 0) begin
      $display("[path_string_word_hash_top] OK");
    end else begin
      $display("[path_string_word_hash_top] ERROR");
    end
    $finish;
  end

  initial begin
    ids_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 5) == 0) begin
        ids_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      ids_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Result checking and the watchdog on cycles with no transfer at all.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (ids_ch.valid && ids_ch.ready) board.check_guid(ids_ch.guid);
      if ((ids_ch.valid && ids_ch.ready) || (words_ch.valid && words_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("[path_string_word_hash_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end
endmodule

// ===== files.f =====
hw/rtl/pswh_pkg.sv
hw/rtl/pswh_if.sv
hw/rtl/path_string_word_hash_top.sv
hw/rtl/pswh_checker.sv
tb/tb_path_string_word_hash_top.sv
